// ===== src/bvrs_pkg.sv =====
// Shared types, constants and helper functions of the rank/select bit vector.
`timescale 1ns / 1ps
`default_nettype none
package bvrs_pkg;

  localparam int MAX_BITS  = 4096;
  localparam int WORD_BITS = 64;
  localparam int WORDS     = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = $clog2(WORDS);
  localparam int BIT_AW    = $clog2(WORD_BITS);
  localparam int CNT_W     = $clog2(WORD_BITS + 1);
  localparam int IDX_W     = 13;
  localparam int RANK_W    = 12;
  localparam int MODE_W    = 3;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   waddr_t;
  typedef logic [BIT_AW-1:0]    bitpos_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [MODE_W-1:0]    mode_t;

  localparam mode_t MODE_GET   = 3'd0;
  localparam mode_t MODE_SET   = 3'd1;
  localparam mode_t MODE_COUNT = 3'd2;
  localparam mode_t MODE_FIND  = 3'd3;
  localparam mode_t MODE_FILL  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_SELECT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  start;
    word_t word;
    rank_t rem;
  } sel_req_t;

  typedef struct packed {
    logic    done;
    bitpos_t pos;
  } sel_rsp_t;

  function automatic cnt_t word_ones(word_t w);
    cnt_t n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + cnt_t'(w[i]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== src/bvrs_word_ram.sv =====
// Word store: synchronous RAM with a per-word valid bit so unwritten words read as zero.
`timescale 1ns / 1ps
`default_nettype none
module bvrs_word_ram (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           rd_en,
  input  wire bvrs_pkg::waddr_t rd_addr,
  output bvrs_pkg::word_t     rd_data,
  input  wire logic           wr_en,
  input  wire bvrs_pkg::waddr_t wr_addr,
  input  wire bvrs_pkg::word_t  wr_data
);
  import bvrs_pkg::*;

  word_t             mem [WORDS];
  logic [WORDS-1:0]  vld;
  word_t             rd_q;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // a word never written reads as the cleared value
  assign rd_data = rd_vld ? rd_q : '0;

endmodule
`default_nettype wire

// ===== src/bvrs_select.sv =====
// Byte-serial unit that locates the n-th one inside one word.
`timescale 1ns / 1ps
`default_nettype none
module bvrs_select (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bvrs_pkg::sel_req_t req,
  output bvrs_pkg::sel_rsp_t      rsp
);
  import bvrs_pkg::*;

  function automatic logic [3:0] byte_ones(logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int j = 0; j < 8; j++) begin
      n = n + 4'(b[j]);
    end
    return n;
  endfunction

  function automatic logic [2:0] byte_pick(logic [7:0] b, logic [3:0] r);
    logic [3:0] seen;
    logic [2:0] p;
    logic       hit;
    seen = '0;
    p    = '0;
    hit  = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (b[j] && !hit) begin
        if (seen == r) begin
          hit = 1'b1;
          p   = 3'(j);
        end
        seen = seen + 4'd1;
      end
    end
    return p;
  endfunction

  logic       busy;
  word_t      sh;
  rank_t      rem;
  bitpos_t    base;
  logic [3:0] bc;

  assign bc = byte_ones(sh[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= !req.start && busy && (rem < rank_t'(bc));
      if (req.start) begin
        busy <= 1'b1;
        sh   <= req.word;
        rem  <= req.rem;
        base <= '0;
      end else if (busy) begin
        if (rem < rank_t'(bc)) begin
          busy     <= 1'b0;
          rsp.pos  <= base + bitpos_t'(byte_pick(sh[7:0], rem[3:0]));
        end else begin
          // drop this byte and advance to the next
          rem  <= rem - rank_t'(bc);
          sh   <= sh >> 8;
          base <= base + bitpos_t'(8);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/bit_vector_rank_select.sv =====
// Top level of the rank/select bit vector: request sequencer, word walk and result register.
`timescale 1ns / 1ps
`default_nettype none
// Rank/select bit vector over a 4096-bit store held as 64 words of 64 bits in one
// synchronous RAM. One transaction is worked at a time: get and set go through setup,
// one RAM read, one update and a result load; count and fill walk every word that the
// clamped range touches; find walks the words up to the one holding the sought one
// (or to the end of the length) and then runs the byte-serial select unit. The word
// walk issues one RAM read per cycle; a full-length range walks at most 64 words. The
// store reads as all zeros right after reset, with no clearing pass. The user is to
// see that bit_length is written only while the block is idle; the block itself does
// not enforce it. Values above 4096 act as 4096. A result waits in the output
// register while the next transaction is accepted.
module bit_vector_rank_select (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bvrs_pkg::mode_t      mode,
  input  wire bvrs_pkg::idx_t       index_lo,
  input  wire bvrs_pkg::idx_t       index_hi,
  input  wire logic                 bit_value,
  input  wire bvrs_pkg::rank_t      rank,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bvrs_pkg::idx_t            answer,
  output logic                      flag,
  // configuration channel: bit_length
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire bvrs_pkg::idx_t       cfg_data
);
  import bvrs_pkg::*;

  state_t   state, state_next;

  // held request
  mode_t    op_mode;
  idx_t     op_lo, op_hi;
  logic     op_val;
  rank_t    op_rank;

  idx_t     bit_length;

  // walk range
  waddr_t   lo_word, lo_word_next;
  waddr_t   end_word, end_word_next;
  bitpos_t  lo_bit, lo_bit_next;
  bitpos_t  end_bit, end_bit_next;

  // read issue and the word coming back from RAM
  waddr_t   rd_word, rd_word_next;
  logic     rd_more, rd_more_next;
  logic     rd_en;
  logic     pv;
  waddr_t   pw;
  word_t    rd_data;

  // accumulators and result
  idx_t     acc, acc_next;
  rank_t    rem, rem_next;
  waddr_t   fw, fw_next;
  idx_t     res_answer, res_answer_next;
  logic     res_flag, res_flag_next;
  logic     out_load;

  logic     wr_en;
  word_t    wr_data;

  sel_req_t sel_req;
  sel_rsp_t sel_rsp;

  // setup terms
  idx_t     len, hi_c, rng_end, rng_last;
  logic     rng_ok;

  // word terms
  word_t    mask, dm, set_word, fill_word;
  cnt_t     c;
  logic     last;

  bvrs_word_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_word),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pw),
    .wr_data (wr_data)
  );

  bvrs_select u_sel (
    .clk (clk),
    .rst (rst),
    .req (sel_req),
    .rsp (sel_rsp)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // clamp the length and work out which words the operation touches
  always_comb begin
    len  = (bit_length > idx_t'(MAX_BITS)) ? idx_t'(MAX_BITS) : bit_length;
    hi_c = (op_hi > len) ? len : op_hi;
    case (op_mode)
      MODE_GET, MODE_SET: begin
        rng_ok  = (op_lo < len);
        rng_end = op_lo + idx_t'(1);
      end
      MODE_COUNT, MODE_FILL: begin
        rng_ok  = (hi_c > op_lo);
        rng_end = hi_c;
      end
      MODE_FIND: begin
        rng_ok  = (op_lo < len);
        rng_end = len;
      end
      default: begin
        rng_ok  = 1'b0;
        rng_end = '0;
      end
    endcase
    rng_last = rng_end - idx_t'(1);
  end

  // mask the word under process to the part of the range inside it
  always_comb begin
    mask = '1;
    if (pw == lo_word) begin
      mask = mask & (word_t'('1) << lo_bit);
    end
    if (pw == end_word) begin
      mask = mask & (word_t'('1) >> (bitpos_t'(WORD_BITS - 1) - end_bit));
    end
    dm        = rd_data & mask;
    c         = word_ones(dm);
    last      = (pw == end_word);
    set_word  = rd_data;
    set_word[lo_bit] = op_val;
    fill_word = op_val ? (rd_data | mask) : (rd_data & ~mask);
  end

  // next state and datapath control
  always_comb begin
    state_next      = state;
    lo_word_next    = lo_word;
    end_word_next   = end_word;
    lo_bit_next     = lo_bit;
    end_bit_next    = end_bit;
    rd_word_next    = rd_word;
    rd_more_next    = rd_more;
    acc_next        = acc;
    rem_next        = rem;
    fw_next         = fw;
    res_answer_next = res_answer;
    res_flag_next   = res_flag;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_data         = set_word;
    out_load        = 1'b0;
    sel_req.start   = 1'b0;
    sel_req.word    = dm;
    sel_req.rem     = rem;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SETUP;
        end
      end

      ST_SETUP: begin
        lo_word_next    = op_lo[BIT_AW +: WORD_AW];
        lo_bit_next     = op_lo[BIT_AW-1:0];
        end_word_next   = rng_last[BIT_AW +: WORD_AW];
        end_bit_next    = rng_last[BIT_AW-1:0];
        rd_word_next    = op_lo[BIT_AW +: WORD_AW];
        rd_more_next    = 1'b1;
        acc_next        = '0;
        rem_next        = op_rank;
        res_answer_next = '0;
        res_flag_next   = 1'b0;
        // empty ranges and unused modes answer zero at once
        state_next      = rng_ok ? ST_WALK : ST_DONE;
      end

      ST_WALK: begin
        if (rd_more) begin
          rd_en        = 1'b1;
          rd_word_next = rd_word + waddr_t'(1);
          rd_more_next = (rd_word != end_word);
        end
        if (pv) begin
          case (op_mode)
            MODE_GET: begin
              res_answer_next = idx_t'(rd_data[lo_bit]);
              state_next      = ST_DONE;
            end
            MODE_SET: begin
              wr_en         = 1'b1;
              wr_data       = set_word;
              res_flag_next = rd_data[lo_bit] ^ op_val;
              state_next    = ST_DONE;
            end
            MODE_COUNT: begin
              acc_next = acc + idx_t'(c);
              if (last) begin
                res_answer_next = acc + idx_t'(c);
                state_next      = ST_DONE;
              end
            end
            MODE_FIND: begin
              if (rem < rank_t'(c)) begin
                // the sought one lies in this word: hand it to the select unit
                sel_req.start = 1'b1;
                fw_next       = pw;
                state_next    = ST_SELECT;
              end else begin
                rem_next = rem - rank_t'(c);
                if (last) begin
                  state_next = ST_DONE;
                end
              end
            end
            MODE_FILL: begin
              wr_en   = 1'b1;
              wr_data = fill_word;
              if (last) begin
                state_next = ST_DONE;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_SELECT: begin
        if (sel_rsp.done) begin
          res_answer_next = idx_t'({fw, sel_rsp.pos});
          res_flag_next   = 1'b1;
          state_next      = ST_DONE;
        end
      end

      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pv         <= 1'b0;
      rd_more    <= 1'b0;
      out_valid  <= 1'b0;
      bit_length <= idx_t'(MAX_BITS);
    end else begin
      pv      <= rd_en;
      rd_more <= rd_more_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        bit_length <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_mode <= mode;
      op_lo   <= index_lo;
      op_hi   <= index_hi;
      op_val  <= bit_value;
      op_rank <= rank;
    end
    pw         <= rd_word;
    lo_word    <= lo_word_next;
    end_word   <= end_word_next;
    lo_bit     <= lo_bit_next;
    end_bit    <= end_bit_next;
    rd_word    <= rd_word_next;
    acc        <= acc_next;
    rem        <= rem_next;
    fw         <= fw_next;
    res_answer <= res_answer_next;
    res_flag   <= res_flag_next;
    if (out_load) begin
      answer <= res_answer;
      flag   <= res_flag;
    end
  end

endmodule
`default_nettype wire

// ===== test/bit_vector_rank_select_test.sv =====
// Self-checking testbench of the rank/select bit vector with a shadow store predictor.
`timescale 1ns / 1ps
module bit_vector_rank_select_test;
  import bvrs_pkg::*;

  // Codes without an operation behind them; the block must leave the store alone.
  localparam mode_t MODE_SPARE_A = 3'd5;
  localparam mode_t MODE_SPARE_B = 3'd6;
  localparam mode_t MODE_SPARE_C = 3'd7;

  // The limit takes the worst-case transaction, plus gaps and stalls, several times
  // over for roughly 650 transactions.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct {
    mode_t       op;
    idx_t        lo;
    idx_t        hi;
    logic        val;
    rank_t       nth;
    int unsigned pause;
  } request_t;

  typedef struct {
    idx_t answer;
    logic flag;
  } result_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;

  logic  in_valid = 1'b0;
  logic  in_stall;
  mode_t mode = '0;
  idx_t  index_lo = '0;
  idx_t  index_hi = '0;
  logic  bit_value = 1'b0;
  rank_t rank = '0;

  logic  out_valid;
  logic  out_stall = 1'b0;
  idx_t  answer;
  logic  flag;

  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  idx_t  cfg_data = '0;

  // Shadow copy of the store, advanced at every accepted transaction, and of bit_length.
  word_t       shadow_words [WORDS];
  int unsigned shadow_length;

  request_t    queued_requests [$];
  result_t     expected_results [$];
  int unsigned requests_queued = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_count = 0;
  int unsigned rx_wait = 0;
  logic        calm = 1'b0;

  bit_vector_rank_select u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .index_lo  (index_lo),
    .index_hi  (index_hi),
    .bit_value (bit_value),
    .rank      (rank),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .answer    (answer),
    .flag      (flag),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs on a handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic shadow_bit(int unsigned ix);
    return shadow_words[ix / WORD_BITS][ix % WORD_BITS];
  endfunction

  // Work out the answer and flag of one transaction and apply its writes to the
  // shadow store. Lengths above the store act as the full store.
  function automatic result_t predict_result(request_t r);
    result_t     res;
    int unsigned len;
    int unsigned hi;
    int unsigned seen;
    res.answer = '0;
    res.flag = 1'b0;
    seen = 0;
    len = (shadow_length > MAX_BITS) ? MAX_BITS : shadow_length;
    hi = (r.hi > len) ? len : r.hi;
    case (r.op)
      MODE_GET: begin
        if (r.lo < len) res.answer = idx_t'(shadow_bit(r.lo));
      end
      MODE_SET: begin
        // Writes past the length are dropped.
        if (r.lo < len) begin
          res.flag = (shadow_bit(r.lo) != r.val);
          shadow_words[r.lo / WORD_BITS][r.lo % WORD_BITS] = r.val;
        end
      end
      MODE_COUNT: begin
        for (int unsigned i = r.lo; i < hi; i++) seen += shadow_bit(i);
        res.answer = idx_t'(seen);
      end
      MODE_FIND: begin
        // A start at or past the length finds nothing.
        for (int unsigned i = r.lo; i < len; i++) begin
          if (shadow_bit(i)) begin
            if (seen == r.nth) begin
              res.answer = idx_t'(i);
              res.flag = 1'b1;
              break;
            end
            seen++;
          end
        end
      end
      MODE_FILL: begin
        for (int unsigned i = r.lo; i < hi; i++) begin
          shadow_words[i / WORD_BITS][i % WORD_BITS] = r.val;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Request driver: hold each transaction until accepted, then wait out the
  // pause drawn for the next one before raising valid again.
  always @(posedge clk) begin : request_driver
    request_t next_req;
    if (rst) begin
      in_valid <= 1'b0;
      hold_count <= 0;
    end else if (!in_valid || !in_stall) begin
      if (queued_requests.size() != 0 && hold_count >= queued_requests[0].pause) begin
        next_req = queued_requests.pop_front();
        mode <= next_req.op;
        index_lo <= next_req.lo;
        index_hi <= next_req.hi;
        bit_value <= next_req.val;
        rank <= next_req.nth;
        in_valid <= 1'b1;
        hold_count <= 0;
      end else begin
        in_valid <= 1'b0;
        if (queued_requests.size() != 0) hold_count <= hold_count + 1;
      end
    end
  end

  // Predict at acceptance, from the payload that the edge sampled.
  always @(posedge clk) begin : request_predictor
    request_t seen_req;
    if (!rst && in_valid && !in_stall) begin
      seen_req.op = mode;
      seen_req.lo = index_lo;
      seen_req.hi = index_hi;
      seen_req.val = bit_value;
      seen_req.nth = rank;
      seen_req.pause = 0;
      expected_results.push_back(predict_result(seen_req));
    end
  end

  // Result monitor: check each accepted result against the oldest expectation,
  // then raise the stall while the next result is waiting, until a drawn wait runs out.
  always @(posedge clk) begin : result_monitor
    result_t     want;
    int unsigned next_wait;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else begin
      next_wait = rx_wait;
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual answer %0d flag %0b",
                   $time, answer, flag);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (answer !== want.answer) begin
            $display("%0t: answer mismatch, expected %0d, actual %0d",
                     $time, want.answer, answer);
            error_count++;
          end
          if (flag !== want.flag) begin
            $display("%0t: flag mismatch, expected %0b, actual %0b",
                     $time, want.flag, flag);
            error_count++;
          end
        end
        next_wait = calm ? 0 : $urandom_range(0, 5);
      end else if (out_valid && next_wait > 0) begin
        next_wait = next_wait - 1;
      end
      out_stall <= (next_wait > 0);
      rx_wait <= next_wait;
    end
  end

  task automatic add_request(input mode_t op, input int unsigned lo, input int unsigned hi,
                             input logic val, input int unsigned nth);
    request_t r;
    r.op = op;
    r.lo = idx_t'(lo);
    r.hi = idx_t'(hi);
    r.val = val;
    r.nth = rank_t'(nth);
    r.pause = calm ? 0 : $urandom_range(0, 5);
    queued_requests.push_back(r);
    requests_queued++;
  endtask

  // Hold until every queued transaction has produced its result.
  task automatic wait_drained();
    while (results_seen != requests_queued) @(posedge clk);
  endtask

  // Write bit_length; only called while the block is idle.
  task automatic write_length(input int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= idx_t'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_length = value & 32'h1FFF;
  endtask

  // Bias indices toward the edges of the length in use, with some anywhere in 13 bits.
  function automatic int unsigned pick_index(int unsigned eff);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return eff;
      2: return (eff > 0) ? eff - 1 : 0;
      3: return $urandom_range(0, 8191);
      default: return (eff > 0) ? $urandom_range(0, eff - 1) : $urandom_range(0, 64);
    endcase
  endfunction

  task automatic add_random_requests(input int unsigned count);
    int unsigned eff;
    int unsigned lo;
    int unsigned hi;
    int unsigned nth;
    int unsigned pick;
    mode_t       op;
    eff = (shadow_length > MAX_BITS) ? MAX_BITS : shadow_length;
    for (int unsigned n = 0; n < count; n++) begin
      // Alternate stretches with and without idling on both sides.
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 20) op = MODE_GET;
      else if (pick < 45) op = MODE_SET;
      else if (pick < 65) op = MODE_COUNT;
      else if (pick < 85) op = MODE_FIND;
      else if (pick < 97) op = MODE_FILL;
      else op = mode_t'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
      lo = pick_index(eff);
      // Keep most ranges short so the walk stays quick; a few span everything.
      case ($urandom_range(0, 7))
        0: hi = pick_index(eff);
        1: hi = $urandom_range(0, 8191);
        2: hi = (lo > 0) ? $urandom_range(0, lo) : 0;
        default: hi = lo + $urandom_range(0, 200);
      endcase
      if (hi > 8191) hi = 8191;
      pick = $urandom_range(0, 9);
      if (pick < 7) nth = $urandom_range(0, 15);
      else if (pick < 9) nth = $urandom_range(0, 300);
      else nth = $urandom_range(0, 4095);
      add_request(op, lo, hi, ($urandom_range(0, 2) != 0), nth);
    end
  endtask

  initial begin
    foreach (shadow_words[w]) shadow_words[w] = '0;
    shadow_length = MAX_BITS;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset length of 4096.
    add_request(MODE_GET, 0, 0, 1'b0, 0);           // cleared store reads zero
    add_request(MODE_SET, 0, 0, 1'b1, 0);           // changes
    add_request(MODE_SET, 0, 0, 1'b1, 0);           // no change
    add_request(MODE_SET, 4095, 0, 1'b1, 0);        // top bit
    add_request(MODE_GET, 4095, 0, 1'b0, 0);
    add_request(MODE_GET, 4096, 0, 1'b0, 0);        // read past the length
    add_request(MODE_SET, 4096, 0, 1'b1, 0);        // write past the length is dropped
    add_request(MODE_SET, 8191, 8191, 1'b1, 4095);  // all index bits high
    add_request(MODE_COUNT, 0, 4096, 1'b0, 0);
    add_request(MODE_COUNT, 0, 8191, 1'b0, 0);      // end clamped to the length
    add_request(MODE_COUNT, 100, 50, 1'b0, 0);      // empty range
    add_request(MODE_FIND, 0, 0, 1'b0, 0);
    add_request(MODE_FIND, 0, 0, 1'b0, 1);
    add_request(MODE_FIND, 0, 0, 1'b0, 2);          // not enough ones
    add_request(MODE_FIND, 4096, 0, 1'b0, 0);       // start past the length
    add_request(MODE_FILL, 64, 200, 1'b1, 0);
    add_request(MODE_COUNT, 0, 4096, 1'b0, 0);
    add_request(MODE_FIND, 0, 0, 1'b0, 4095);       // largest rank, not found
    add_request(MODE_FILL, 0, 8191, 1'b1, 0);       // whole store, end clamped
    add_request(MODE_COUNT, 0, 4096, 1'b0, 0);      // largest count
    add_request(MODE_FIND, 0, 0, 1'b0, 4095);       // largest rank, found at the top
    add_request(MODE_FILL, 100, 100, 1'b0, 0);      // empty fill writes nothing
    add_request(MODE_FILL, 0, 4096, 1'b0, 0);
    add_request(MODE_SPARE_A, 5, 9, 1'b1, 3);
    add_request(MODE_SPARE_B, 4096, 8191, 1'b1, 4095);
    add_request(MODE_SPARE_C, 0, 4096, 1'b1, 0);
    add_request(MODE_COUNT, 0, 4096, 1'b0, 0);      // spare codes left the store alone
    wait_drained();

    // Random phases at several lengths, the extremes among them.
    add_random_requests(90);
    wait_drained();
    write_length(1);
    add_random_requests(30);
    wait_drained();
    write_length(0);                                // no bit in use
    add_random_requests(25);
    wait_drained();
    write_length(64);
    add_random_requests(70);
    wait_drained();
    write_length(65);
    add_random_requests(70);
    wait_drained();
    write_length(8191);                             // beyond the store
    add_random_requests(80);
    wait_drained();
    write_length(4095);
    add_random_requests(80);
    wait_drained();
    write_length(200);
    add_random_requests(70);
    wait_drained();
    write_length($urandom_range(2, 4096));
    add_random_requests(75);
    wait_drained();
    write_length(4096);
    add_random_requests(40);
    wait_drained();

    // Give a stray result time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
